FILE: rtl/abpp_pkg.sv
// Package for the alpha blend pixel plotter: sizes, controller states,
// command and status structs, and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package abpp_pkg;

	localparam int FRAME_PIXELS = 262144;
	localparam int FB_AW        = $clog2(FRAME_PIXELS);
	localparam int IDX_W        = 18;
	localparam int PIX_W        = 32;
	localparam int CHAN_W       = 8;
	localparam int RGB_W        = 3 * CHAN_W;
	localparam int NUM_CHAN     = 3;
	localparam int IN_W         = 56;
	localparam int PROD_W       = 2 * CHAN_W;

	localparam logic [CHAN_W-1:0] ALPHA_NONE = 8'h00;
	localparam logic [CHAN_W-1:0] ALPHA_FULL = 8'hFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MULT,
		ST_FINISH
	} abpp_state_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic rd;
		logic mul;
		logic fin;
	} abpp_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic out_free;
	} abpp_stat_t;

	// Exact floor(x / 255) for any product of two bytes.
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		t = (PROD_W+1)'(x) + (PROD_W+1)'(x >> CHAN_W) + (PROD_W+1)'(1);
		return t[PROD_W-1:CHAN_W];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/abpp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module abpp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/abpp_ctrl.sv
// Controller state machine: clearing pass after reset, then one word at a
// time through read, multiply and finish. Depends on abpp_pkg.
`default_nettype none

module abpp_ctrl import abpp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire abpp_stat_t stat,
	output abpp_cmd_t       cmd
);

	abpp_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_READ;
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mul = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (stat.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/abpp_dpath.sv
// Datapath: input registers, frame store, channel multipliers, blend and
// output register. Depends on abpp_pkg and abpp_ram.
`default_nettype none

module abpp_dpath import abpp_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire abpp_cmd_t       cmd,
	output abpp_stat_t           stat,
	input  wire logic [IN_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic      [RGB_W-1:0] m_tdata,
	output logic      [0:0]      m_tuser
);

	logic [FB_AW-1:0]  clr_cnt_q;
	logic [FB_AW-1:0]  addr_q;
	logic [PIX_W-1:0]  px_q;
	logic              in_rng_q;
	logic [RGB_W-1:0]  rdata;
	logic [RGB_W-1:0]  cur_s2;
	logic [PROD_W-1:0] ps_s2 [NUM_CHAN];
	logic [PROD_W-1:0] pd_s2 [NUM_CHAN];
	logic [CHAN_W-1:0] alpha;
	logic [CHAN_W-1:0] alpha_inv;
	logic [RGB_W-1:0]  blend;
	logic [RGB_W-1:0]  src_rgb;
	logic [RGB_W-1:0]  new_val;
	logic              do_write;
	logic              ram_we;
	logic [FB_AW-1:0]  ram_waddr;
	logic [RGB_W-1:0]  ram_wdata;
	logic              out_valid_q;
	logic [RGB_W-1:0]  out_data_q;
	logic              out_wr_q;
	logic [IDX_W-1:0]  in_idx;

	assign in_idx    = s_tdata[IDX_W-1:0];
	assign alpha     = px_q[CHAN_W-1:0];
	assign alpha_inv = ALPHA_FULL - alpha;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clr) begin
			clr_cnt_q <= clr_cnt_q + FB_AW'(1);
		end
	end

	assign stat.clr_last = (clr_cnt_q == FB_AW'(FRAME_PIXELS - 1));
	assign stat.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			addr_q   <= FB_AW'(in_idx);
			px_q     <= s_tdata[IDX_W +: PIX_W];
			in_rng_q <= (32'(in_idx) < 32'(FRAME_PIXELS));
		end
	end

	abpp_ram #(
		.WIDTH (RGB_W),
		.DEPTH (FRAME_PIXELS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (addr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			cur_s2 <= rdata;
			for (int c = 0; c < NUM_CHAN; c++) begin
				ps_s2[c] <= PROD_W'(px_q[CHAN_W*(NUM_CHAN-c) +: CHAN_W]) * PROD_W'(alpha);
				pd_s2[c] <= PROD_W'(rdata[CHAN_W*c +: CHAN_W]) * PROD_W'(alpha_inv);
			end
		end
	end

	always_comb begin
		logic [CHAN_W:0] sum;
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum = (CHAN_W+1)'(div255(ps_s2[c])) + (CHAN_W+1)'(div255(pd_s2[c]));
			blend[CHAN_W*c +: CHAN_W]   = sum[CHAN_W-1:0];
			src_rgb[CHAN_W*c +: CHAN_W] = px_q[CHAN_W*(NUM_CHAN-c) +: CHAN_W];
		end
	end

	always_comb begin
		do_write = in_rng_q && (alpha != ALPHA_NONE);
		if (!in_rng_q) begin
			new_val = '0;
		end else if (alpha == ALPHA_NONE) begin
			new_val = cur_s2;
		end else if (alpha == ALPHA_FULL) begin
			new_val = src_rgb;
		end else begin
			new_val = blend;
		end
	end

	assign ram_we    = cmd.clr || (cmd.fin && do_write);
	assign ram_waddr = cmd.clr ? clr_cnt_q : addr_q;
	assign ram_wdata = cmd.clr ? '0 : new_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			out_data_q <= new_val;
			out_wr_q   <= do_write;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_wr_q;

endmodule

`default_nettype wire

FILE: rtl/alpha_blend_pixel_plotter_unit.sv
// Top level of the alpha blend pixel plotter: controller plus datapath.
// Depends on abpp_pkg, abpp_ctrl and abpp_dpath.
//
//   Channel  Direction  Bits  Contents
//   s        in         56    pixel_index [17:0], source_pixel [49:18]
//   m        out        24+1  stored_value in tdata, was_written in tuser
//
// After reset the frame store is cleared one entry per cycle, all
// FRAME_PIXELS (262144) entries; s_tready stays low during that pass.
// A word passes through accept, store read, multiply, blend and write.
// The next word is accepted in the cycle after the result is registered,
// so a word is taken only once the one before it has finished.
// A result waiting on m_tready does not block the next word until that
// word reaches its finish step.
`default_nettype none

module alpha_blend_pixel_plotter_unit import abpp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // pixel_index, source_pixel, zero fill
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [RGB_W-1:0] m_tdata,  // stored_value
	output logic      [0:0]       m_tuser   // was_written
);

	abpp_cmd_t  cmd;
	abpp_stat_t stat;

	abpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	abpp_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

FILE: rtl/abpp_checker.sv
// Port-level checker for the alpha blend pixel plotter, bound to the top
// level. Depends on abpp_pkg.
`default_nettype none

module abpp_checker import abpp_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_tvalid,
	input wire logic             s_tready,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [RGB_W-1:0] m_tdata,
	input wire logic [0:0]       m_tuser
);

	logic s_acc;
	assign s_acc = s_tvalid && s_tready;

	// A stalled result word holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// A word keeps the input side closed through its read, multiply and finish steps.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("new word accepted while one is in flight");

	// A result appears only out of the finish step, in which the input side is closed.
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared outside the finish step");

	// No result rises straight after a word is accepted.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc |=> !$rose(m_tvalid))
		else $error("result appeared right after acceptance");

endmodule

bind alpha_blend_pixel_plotter_unit abpp_checker u_abpp_checker (.*);

`default_nettype wire

FILE: tb/alpha_blend_pixel_plotter_unit_tb.sv
// Self-checking testbench for alpha_blend_pixel_plotter_unit: directed and random pixels,
// predicted against a mirror of the frame store, under several idle and stall patterns.
// Depends on abpp_pkg and the RTL of the plotter.

module alpha_blend_pixel_plotter_unit_tb;
	import abpp_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 11;
	localparam int PHASE_PIXELS = 475;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE       = 20;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int REPORT_MAX   = 10;

	class frame_mirror;
		typedef struct {
			logic             written;
			logic [RGB_W-1:0] value;
		} plot_result_t;

		logic [RGB_W-1:0] frame [int unsigned];
		plot_result_t     awaited [$];
		int unsigned      plotted, checked, mismatches, skips, overwrites, blends;

		function logic [CHAN_W-1:0] mix(logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] d,
				logic [CHAN_W-1:0] a);
			int unsigned sum;
			sum = (int'(s) * int'(a)) / 255 + (int'(d) * (255 - int'(a))) / 255;
			return CHAN_W'(sum);
		endfunction

		// Notes an accepted pixel and queues the entry it must leave behind.
		function void plot(logic [IDX_W-1:0] idx, logic [PIX_W-1:0] src);
			logic [CHAN_W-1:0] a;
			logic [RGB_W-1:0]  cur;
			logic [RGB_W-1:0]  nv;
			plot_result_t      res;
			a = src[7:0];
			cur = frame.exists(idx) ? frame[idx] : '0;
			plotted++;
			if (a == ALPHA_NONE) begin
				skips++;
				res.written = 1'b0;
				res.value   = cur;
			end else begin
				if (a == ALPHA_FULL) begin
					overwrites++;
					nv = {src[15:8], src[23:16], src[31:24]};
				end else begin
					blends++;
					nv = {mix(src[15:8], cur[23:16], a), mix(src[23:16], cur[15:8], a),
						mix(src[31:24], cur[7:0], a)};
				end
				frame[idx]  = nv;
				res.written = 1'b1;
				res.value   = nv;
			end
			awaited.push_back(res);
		endfunction

		function void compare(logic written, logic [RGB_W-1:0] value);
			plot_result_t res;
			checked++;
			if (awaited.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: unexpected word written=%0b value=%06h", written, value);
				return;
			end
			res = awaited.pop_front();
			if (written !== res.written || value !== res.value) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: word %0d expected written=%0b value=%06h, got written=%0b value=%06h",
						checked, res.written, res.value, written, value);
			end
		endfunction

		function int pending();
			return awaited.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [RGB_W-1:0] m_tdata;
	logic [0:0]       m_tuser;

	frame_mirror      mirror = new();
	int               send_idle_pct;
	int               recv_stall_pct;
	int               hold_request;
	int               hold_left;
	int unsigned      cycle_count;
	logic [IDX_W-1:0] last_index;
	logic [IDX_W-1:0] hot_index [8];

	alpha_blend_pixel_plotter_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				mirror.compare(m_tuser[0], m_tdata);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [PIX_W-1:0] src);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_W - IDX_W - PIX_W){1'b0}}, src, idx};
		do
			@(posedge clk);
		while (!s_tready);
		mirror.plot(idx, src);
		last_index = idx;
	endtask

	task automatic run_random_phase(input int sidle, input int rstall, input int count);
		logic [IDX_W-1:0]  idx;
		logic [PIX_W-1:0]  color;
		logic [CHAN_W-1:0] a;
		int                r;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 35)
				idx = hot_index[$urandom_range(7)];
			else if (r < 55)
				idx = last_index;
			else if (r < 65)
				idx = last_index + IDX_W'(1);
			else
				idx = IDX_W'($urandom());
			r = $urandom_range(99);
			if (r < 12)
				a = ALPHA_NONE;
			else if (r < 24)
				a = ALPHA_FULL;
			else if (r < 30)
				a = 8'd1;
			else if (r < 36)
				a = 8'd254;
			else
				a = CHAN_W'($urandom());
			color = $urandom();
			send_pixel(idx, {color[31:8], a});
		end
	endtask

	initial begin
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 0;
		last_index     = '0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		hot_index[0] = '0;
		hot_index[1] = '1;
		for (int i = 2; i < 8; i++)
			hot_index[i] = IDX_W'($urandom());
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Corners of index and alpha, repeated hits on one entry, and zero alpha on
		// both untouched and written entries.
		send_pixel(18'h00000, 32'h00000000);
		send_pixel(18'h00000, 32'hFFFFFFFF);
		send_pixel(18'h00000, 32'h00000080);
		send_pixel(18'h00000, 32'h00000000);
		send_pixel(18'h3FFFF, 32'hFFFFFFFF);
		send_pixel(18'h3FFFF, 32'h00000001);
		send_pixel(18'h3FFFF, 32'hFFFFFFFE);
		send_pixel(18'h2AAAA, 32'h332211FF);
		send_pixel(18'h15555, 32'hCCDDEEFF);
		send_pixel(18'h2AAAA, 32'hFFFFFF80);
		send_pixel(18'h2AAAA, 32'h00000001);
		send_pixel(18'h15555, 32'h12345600);
		send_pixel(18'h15555, 32'h00FF00FE);
		send_pixel(18'h00001, 32'h80808080);
		send_pixel(18'h00001, 32'h80808080);
		send_pixel(18'h00001, 32'h80808080);
		send_pixel(18'h00002, 32'h010203FF);
		send_pixel(18'h00001, 32'h7F7F7F7F);
		send_pixel(18'h3FFFF, 32'h00000000);

		// The receiver holds off for a long stretch while pixels keep coming.
		hold_request = HOLD_CYCLES;
		run_random_phase(0, 0, PHASE_PIXELS);
		run_random_phase(52, 0, PHASE_PIXELS);
		run_random_phase(0, 52, PHASE_PIXELS);
		run_random_phase(26, 26, PHASE_PIXELS);
		s_tvalid <= 1'b0;

		while (mirror.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Plotted %0d pixels: %0d overwrites, %0d blends, %0d left alone at zero alpha.",
			mirror.plotted, mirror.overwrites, mirror.blends, mirror.skips);
		$display("Checked %0d result words over four idle and stall patterns; %0d mismatches.",
			mirror.checked, mirror.mismatches);
		if (mirror.mismatches == 0 && mirror.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
